// ===== hdl/fpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the function profiling table.
// No dependencies; imported by every module of the block.
package fpt_pkg;

    localparam int unsigned DEF_ENTRIES = 512;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned TICK_W      = 64;
    localparam int unsigned RIDX_W      = 9;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned S_DATA_W    = 112;
    localparam int unsigned M_DATA_W    = 208;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_UPD,
        ST_OUT
    } state_t;

    // Command broadcast to every cell in the update cycle.
    typedef struct packed {
        logic clr;
        logic wr;
        logic alloc;
        logic inc;
        logic add;
    } cell_cmd_t;

endpackage

// ===== hdl/fpt_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds a key, a call count and a tick sum, and matches a key.
// Depends on fpt_pkg.
module fpt_cell
    import fpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ADDR_W-1:0]  key_in,
    input  logic [TICK_W-1:0]  delta,
    input  cell_cmd_t          cmd,
    input  logic               sel,
    output logic               match,
    output logic               free,
    output logic [ADDR_W-1:0]  key_out,
    output logic [COUNT_W-1:0] count_out,
    output logic [TICK_W-1:0]  sum_out
);

    logic [ADDR_W-1:0]  key_reg,   key_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]  sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_base;
    logic [TICK_W-1:0]  sum_base;

    // Compare against the broadcast key.
    assign match = (key_reg == key_in);
    assign free  = (key_reg == '0);

    // A freshly taken cell starts from zero before the event is applied.
    assign count_base = cmd.alloc ? '0 : count_reg;
    assign sum_base   = cmd.alloc ? '0 : sum_reg;

    always_comb begin
        key_next   = key_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (cmd.clr) begin
            key_next   = '0;
            count_next = '0;
            sum_next   = '0;
        end else if (cmd.wr && sel) begin
            key_next   = key_in;
            count_next = cmd.inc ? count_base + 1'b1 : count_base;
            sum_next   = cmd.add ? sum_base + delta : sum_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            key_reg   <= key_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign key_out   = key_reg;
    assign count_out = count_reg;
    assign sum_out   = sum_reg;

endmodule

// ===== hdl/function_profile_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the function profiling table: control sequencer and cell row.
// Depends on fpt_pkg and fpt_cell.

// From acceptance to a loaded result, each item passes these steps in order:
// match the address against every cell in parallel (ST_LOOK), pick the
// matching or lowest free cell, or the read index (ST_SEL), update that cell
// or clear the row (ST_UPD), and gather the result (ST_OUT). The next item is
// accepted in the cycle after the result loads. One item is worked on at a time; the result
// register lets the next item start while the last result still waits, and an
// item holds in its gather step while an earlier result has not been taken.
// All cells are cleared at once by reset or by a clear operation, so no
// clearing pass is needed.
module function_profile_table_top
    import fpt_pkg::*;
#(
    parameter int unsigned ENTRIES = DEF_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: enable register.
    input  logic                cfg_wen,
    input  logic                cfg_wdata,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: address[31:0], timestamp[95:32], read_index[104:96], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser: op[1:0]
    input  logic [OP_W-1:0]     s_tuser,
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: entry_index[8:0], entry_address[40:9], call_count[72:41],
    //        tick_sum[136:73], total_ticks[200:137], zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // tuser: dropped
    output logic                m_tuser
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    state_t state_reg, state_next;

    logic                enable_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [TICK_W-1:0]   ts_reg;
    logic [RIDX_W-1:0]   ridx_reg;
    logic [TICK_W-1:0]   delta_reg;
    logic [TICK_W-1:0]   last_enter_reg;
    logic [TICK_W-1:0]   grand_reg;
    logic                evt_ok_reg;
    logic [ENTRIES-1:0]  match_vec_reg;
    logic [ENTRIES-1:0]  free_vec_reg;
    logic [ENTRIES-1:0]  sel_reg, sel_next;
    logic [RIDX_W-1:0]   idx_reg, idx_next;
    logic                drop_reg, drop_next;
    logic                alloc_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_drop_reg;

    logic [ENTRIES-1:0]  match_vec, free_vec, low_free, rd_vec;
    logic [ADDR_W-1:0]   cell_key   [ENTRIES];
    logic [COUNT_W-1:0]  cell_count [ENTRIES];
    logic [TICK_W-1:0]   cell_sum   [ENTRIES];
    logic [IW-1:0]       enc_idx;
    logic [ADDR_W-1:0]   g_key;
    logic [COUNT_W-1:0]  g_count;
    logic [TICK_W-1:0]   g_sum;
    logic                is_event, hit, any_free;
    cell_cmd_t           cmd;
    logic                accept, load_out, upd_en;

    assign accept   = s_tvalid && s_tready;
    assign is_event = (op_reg == OP_ENTER) || (op_reg == OP_EXIT);

    // Row of cells.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        fpt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key_in    (addr_reg),
            .delta     (delta_reg),
            .cmd       (cmd),
            .sel       (sel_reg[i]),
            .match     (match_vec[i]),
            .free      (free_vec[i]),
            .key_out   (cell_key[i]),
            .count_out (cell_count[i]),
            .sum_out   (cell_sum[i])
        );
        assign rd_vec[i] = (32'(ridx_reg) == i);
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_wen) begin
            enable_reg <= cfg_wdata;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_SEL;
            ST_SEL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready = 1'b0;
        upd_en   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_UPD:  upd_en   = 1'b1;
            ST_OUT:  load_out = !m_valid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the accepted transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata[31:0];
            ts_reg   <= s_tdata[95:32];
            ridx_reg <= s_tdata[104:96];
        end
    end

    // Match stage: register the parallel compare and the elapsed ticks.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            match_vec_reg <= match_vec;
            free_vec_reg  <= free_vec;
            delta_reg     <= ts_reg - last_enter_reg;
            evt_ok_reg    <= enable_reg && (addr_reg != '0);
        end
    end

    // Select stage: the read index for reads; for events the matching cell first, else the lowest free one.
    assign hit      = |match_vec_reg;
    assign any_free = |free_vec_reg;
    assign low_free = free_vec_reg & (~free_vec_reg + 1'b1);

    always_comb begin
        enc_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_next[i]) enc_idx = enc_idx | IW'(i);
        end
    end

    always_comb begin
        sel_next  = '0;
        drop_next = 1'b0;
        if (op_reg == OP_READ) begin
            sel_next = rd_vec;
        end else if (is_event) begin
            if (evt_ok_reg && (hit || any_free)) begin
                sel_next = hit ? match_vec_reg : low_free;
            end else begin
                drop_next = 1'b1;
            end
        end
        idx_next = (op_reg == OP_READ) ? ridx_reg : RIDX_W'(enc_idx);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SEL) begin
            sel_reg   <= sel_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
            alloc_reg <= !hit;
        end
    end

    // Update stage: command broadcast to the row, globals updated here.
    always_comb begin
        cmd       = '0;
        cmd.clr   = upd_en && (op_reg == OP_CLEAR);
        cmd.wr    = upd_en && is_event && !drop_reg;
        cmd.alloc = alloc_reg;
        cmd.inc   = (op_reg == OP_ENTER);
        cmd.add   = (op_reg == OP_EXIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_enter_reg <= '0;
            grand_reg      <= '0;
        end else if (cmd.clr) begin
            last_enter_reg <= '0;
            grand_reg      <= '0;
        end else if (cmd.wr) begin
            if (cmd.inc) last_enter_reg <= ts_reg;
            if (cmd.add) grand_reg      <= grand_reg + delta_reg;
        end
    end

    // Gather the selected cell's contents.
    always_comb begin
        g_key   = '0;
        g_count = '0;
        g_sum   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sel_reg[i]) begin
                g_key   = g_key   | cell_key[i];
                g_count = g_count | cell_count[i];
                g_sum   = g_sum   | cell_sum[i];
            end
        end
    end

    // Result register: the last transfer may wait while new work starts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_drop_reg <= drop_reg;
            m_data_reg <= {7'd0, grand_reg, g_sum, g_count, g_key,
                           (op_reg == OP_CLEAR) ? RIDX_W'(0) : idx_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_drop_reg;

endmodule

// ===== dv/function_profile_table_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for function_profile_table_top: directed table, table fill, then random traffic.
// Depends on fpt_pkg and the function_profile_table_top RTL.
module function_profile_table_top_test;
    import fpt_pkg::*;

    localparam int NSLOT = 512;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [8:0]  idx;
        logic [31:0] addr;
        logic [31:0] calls;
        logic [63:0] ticks;
        logic [63:0] total;
        logic        dropped;
    } prof_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [63:0] stamp;
        logic [8:0]  ridx;
        logic        cfg_en;
        logic        has_fixed;
        prof_result_t fixed;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wen = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    // Predictor state.
    logic [31:0] key_q   [NSLOT];
    logic [31:0] calls_q [NSLOT];
    logic [63:0] ticks_q [NSLOT];
    logic [63:0] enter_stamp;
    logic [63:0] grand_sum;
    logic        prof_enable;

    prof_result_t expected_results[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    function_profile_table_top dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        prof_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{idx: m_tdata[8:0], addr: m_tdata[40:9], calls: m_tdata[72:41],
                    ticks: m_tdata[136:73], total: m_tdata[200:137], dropped: m_tuser};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    function automatic void clear_profile();
        for (int i = 0; i < NSLOT; i++) begin
            key_q[i] = '0;
            calls_q[i] = '0;
            ticks_q[i] = '0;
        end
        enter_stamp = '0;
        grand_sum = '0;
    endfunction

    function automatic prof_result_t slot_view(int slot, logic [8:0] idx);
        prof_result_t r;
        r = '0;
        r.idx = idx;
        if (slot >= 0 && slot < NSLOT) begin
            r.addr = key_q[slot];
            r.calls = calls_q[slot];
            r.ticks = ticks_q[slot];
        end
        r.total = grand_sum;
        return r;
    endfunction

    // Work out the result of one operation and advance the predictor.
    function automatic prof_result_t profile_event(logic [1:0] op, logic [31:0] addr,
                                                   logic [63:0] stamp, logic [8:0] ridx);
        int slot;
        int free_slot;
        prof_result_t r;
        logic [63:0] delta;
        slot = -1;
        free_slot = -1;
        if (op == OP_CLEAR) begin
            clear_profile();
            return slot_view(-1, '0);
        end
        if (op == OP_READ)
            return slot_view(int'(ridx), ridx);
        if (prof_enable && addr != 0) begin
            for (int i = 0; i < NSLOT && slot < 0; i++) begin
                if (key_q[i] == addr) slot = i;
                else if (key_q[i] == 0 && free_slot < 0) free_slot = i;
            end
            if (slot < 0 && free_slot >= 0) begin
                slot = free_slot;
                key_q[slot] = addr;
                calls_q[slot] = '0;
                ticks_q[slot] = '0;
            end
        end
        if (slot < 0) begin
            r = slot_view(-1, '0);
            r.dropped = 1'b1;
            return r;
        end
        if (op == OP_ENTER) begin
            enter_stamp = stamp;
            calls_q[slot] = calls_q[slot] + 32'd1;
        end else begin
            delta = stamp - enter_stamp;
            grand_sum = grand_sum + delta;
            ticks_q[slot] = ticks_q[slot] + delta;
        end
        return slot_view(slot, slot[8:0]);
    endfunction

    // Write the enable register while the block is idle.
    task automatic write_enable(logic val);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        prof_enable = val;
    endtask

    // Present one item, wait for its transfer, queue the expectation.
    task automatic send_op(logic [1:0] op, logic [31:0] addr, logic [63:0] stamp,
                           logic [8:0] ridx, logic has_fixed, prof_result_t fixed);
        prof_result_t r;
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, ridx, stamp, addr};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        r = profile_event(op, addr, stamp, ridx);
        if (has_fixed && r !== fixed) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees: %p vs %p", fixed, r);
        end
        expected_results.push_back(r);
        // The block stays busy after a transfer, so this wait costs no throughput.
        @(posedge aclk);
    endtask

    stim_row_t directed[] = '{
        '{OP_READ,  32'h0, 64'h0, 9'd0, 1'b0, 1'b1, '0},
        '{OP_READ,  32'h0, 64'h0, 9'd511, 1'b0, 1'b1, '{9'd511, 0, 0, 0, 0, 1'b0}},
        '{OP_ENTER, 32'h1234, 64'h10, 9'd0, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 1'b1}},
        '{OP_EXIT,  32'h1234, 64'h20, 9'd0, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 1'b1}},
        '{OP_ENTER, 32'h0, 64'h10, 9'd0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 1'b1}},
        '{OP_ENTER, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 9'd0, 1'b1, 1'b1,
          '{9'd0, 32'hFFFFFFFF, 32'd1, 0, 0, 1'b0}},
        '{OP_EXIT,  32'hFFFFFFFF, 64'h5, 9'd0, 1'b1, 1'b0, '0},
        '{OP_EXIT,  32'h1, 64'h0, 9'd0, 1'b1, 1'b0, '0},
        '{OP_ENTER, 32'h1, 64'h123456789ABCDEF0, 9'd0, 1'b1, 1'b0, '0},
        '{OP_EXIT,  32'h1, 64'hFFFFFFFFFFFFFFFF, 9'd0, 1'b1, 1'b0, '0},
        '{OP_READ,  32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 9'd0, 1'b1, 1'b0, '0},
        '{OP_READ,  32'h0, 64'h0, 9'd1, 1'b1, 1'b0, '0},
        '{OP_READ,  32'h0, 64'h0, 9'd2, 1'b1, 1'b0, '0},
        '{OP_CLEAR, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 9'd511, 1'b1, 1'b1, '0},
        '{OP_READ,  32'h0, 64'h0, 9'd0, 1'b1, 1'b1, '0},
        '{OP_EXIT,  32'h77, 64'h40, 9'd0, 1'b1, 1'b1, '{9'd0, 32'h77, 0, 64'h40, 64'h40, 1'b0}},
        '{OP_CLEAR, 32'h0, 64'h0, 9'd0, 1'b0, 1'b1, '0}
    };

    logic [31:0] hot_addrs[16];
    logic [63:0] clock_now;
    logic [1:0]  op_r;
    logic [31:0] addr_r;
    int pick;

    initial begin
        clear_profile();
        prof_enable = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; each row sets enable if it differs.
        foreach (directed[i]) begin
            if (directed[i].cfg_en !== prof_enable) write_enable(directed[i].cfg_en);
            send_op(directed[i].op, directed[i].addr, directed[i].stamp, directed[i].ridx,
                    directed[i].has_fixed, directed[i].fixed);
        end

        // Fill the table to capacity, then hit it with new keys to exercise drops.
        write_enable(1'b1);
        for (int i = 0; i < NSLOT + 6; i++)
            send_op(OP_ENTER, 32'h1000 + i, 64'(i), 9'(i), 1'b0, '0);
        send_op(OP_EXIT, 32'h1000, 64'hFFFF, 9'd0, 1'b0, '0);
        send_op(OP_READ, '0, '0, 9'd511, 1'b0, '0);
        send_op(OP_CLEAR, '0, '0, '0, 1'b0, '0);

        // Random traffic in three idle phases, mostly enter/exit on hot addresses.
        clock_now = 64'd0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 9 : 0;
            write_enable(phase != 1 ? 1'b1 : 1'b0);
            if (phase == 1) write_enable(1'b1);
            foreach (hot_addrs[k]) hot_addrs[k] = $urandom();
            hot_addrs[0] = 32'hFFFFFFFF;
            for (int n = 0; n < 10; n++) begin
                pick = $urandom_range(99);
                clock_now = clock_now + $urandom_range(1, 300);
                if ($urandom_range(30) == 0) clock_now = {$urandom(), $urandom()};
                addr_r = hot_addrs[$urandom_range(15)];
                if (pick < 40) op_r = OP_ENTER;
                else if (pick < 80) op_r = OP_EXIT;
                else if (pick < 95) op_r = OP_READ;
                else if (pick < 97) op_r = OP_CLEAR;
                else begin
                    op_r = 2'($urandom_range(1));
                    addr_r = ($urandom_range(1) != 0) ? 32'h0 : $urandom();
                end
                send_op(op_r, addr_r, clock_now,
                        ($urandom_range(3) == 0) ? 9'($urandom()) : 9'($urandom_range(20)),
                        1'b0, '0);
                if (n == 5 && phase == 2) begin
                    write_enable(1'b0);
                    send_op(OP_EXIT, hot_addrs[1], clock_now, '0, 1'b0, '0);
                    send_op(OP_READ, '0, '0, 9'd1, 1'b0, '0);
                    write_enable(1'b1);
                end
            end
        end

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fpt_pkg.sv
hdl/fpt_cell.sv
hdl/function_profile_table_top.sv
dv/function_profile_table_top_test.sv
